/* rtl/psbt_pkg.sv */
// types, codes and constants shared by the packet sequence block tracker
// no dependencies
package psbt_pkg;

  localparam int EPOCH_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [1:0] CMD_BLOCK    = 2'd0;
  localparam logic [1:0] CMD_SEQUENCE = 2'd1;
  localparam logic [1:0] CMD_CONSUMED = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  localparam logic [3:0] ST_NEW_BLOCK = 4'd0;
  localparam logic [3:0] ST_DUPLICATE = 4'd1;
  localparam logic [3:0] ST_STALE     = 4'd2;
  localparam logic [3:0] ST_SEQ_OK    = 4'd3;
  localparam logic [3:0] ST_CHROMA    = 4'd4;
  localparam logic [3:0] ST_DIMENSION = 4'd5;
  localparam logic [3:0] ST_CODE      = 4'd6;
  localparam logic [3:0] ST_INDEX     = 4'd7;
  localparam logic [3:0] ST_SHORT     = 4'd8;
  localparam logic [3:0] ST_CONSUMED  = 4'd9;

  localparam logic [3:0] START_OF_FRAME_CODE = 4'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_BLOCKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_PARTIAL = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  sequence_number;
    logic [15:0] block_num;
    logic [15:0] word_count;
    logic [1:0]  chroma_code;
    logic [3:0]  extended_code;
    logic [13:0] width_minus_one;
    logic [13:0] height_minus_one;
    logic [15:0] block_total;
  } psbt_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [23:0] block_offset;
    logic        restarted;
    logic [15:0] decoded_count;
    logic        frame_ready;
  } psbt_out_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic clear_step;
  } psbt_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic wrap;
    logic out_block;
  } psbt_sts_t;

endpackage

/* rtl/psbt_ram.sv */
// generic single write port ram with registered read
// no dependencies
module psbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/psbt_ctrl.sv */
// controller of the tracker: clear pass, accept and execute sequencing
// depends on psbt_pkg
module psbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psbt_pkg::psbt_sts_t sts,
  output psbt_pkg::psbt_cmd_t cmd
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_block) begin
          cmd.commit = 1'b1;
          state_nxt = sts.wrap ? S_CLEAR : S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

/* rtl/psbt_dp.sv */
// datapath of the tracker: config, sequence state, seen tag memory, result register
// depends on psbt_pkg and psbt_ram
module psbt_dp #(
  parameter int MAX_BLOCKS    = 4096,
  parameter int SEQUENCE_MASK = 255,
  parameter int HEADER_WORDS  = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  psbt_pkg::psbt_in_t                   in_data,
  input  logic                                 cfg_wr_en,
  input  logic [psbt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psbt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output psbt_pkg::psbt_out_t                  out_data,
  input  psbt_pkg::psbt_cmd_t                  cmd,
  output psbt_pkg::psbt_sts_t                  sts
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int EW    = psbt_pkg::EPOCH_W;
  localparam logic [7:0] SEQ_MASK = 8'(SEQUENCE_MASK);
  localparam logic [7:0] SEQ_HALF = 8'(SEQUENCE_MASK / 2);
  localparam logic [16:0] BLOCK_LIMIT = 17'(MAX_BLOCKS);
  localparam logic [15:0] HDR_WORDS = 16'(HEADER_WORDS);
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_BLOCKS - 1);
  localparam logic [23:0] FILL_MAX = '1;
  localparam logic [15:0] COUNT_MAX = '1;

  // configuration
  logic [14:0] frame_width_r, frame_height_r;
  logic [1:0]  chroma_mode_r;
  logic [12:0] layout_r;
  logic        allow_partial_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= 15'd1;
      frame_height_r  <= 15'd1;
      chroma_mode_r   <= 2'd0;
      layout_r        <= 13'd0;
      allow_partial_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        psbt_pkg::CFG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata;
        psbt_pkg::CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata;
        psbt_pkg::CFG_CHROMA_MODE:   chroma_mode_r   <= cfg_wdata[1:0];
        psbt_pkg::CFG_LAYOUT_BLOCKS: layout_r        <= cfg_wdata[12:0];
        psbt_pkg::CFG_ALLOW_PARTIAL: allow_partial_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // tracking state
  psbt_pkg::psbt_in_t item_r;
  logic [23:0]    fill_r, fill_nxt;
  logic [15:0]    count_r, count_nxt;
  logic [7:0]     cur_seq_r, cur_seq_nxt;
  logic           seq_valid_r, seq_valid_nxt;
  logic [15:0]    expected_r, expected_nxt;
  logic           consumed_r, consumed_nxt;
  logic [EW-1:0]  epoch_r, epoch_nxt;
  logic           pend_set_r;
  logic [IDX_W-1:0] pend_addr_r;
  logic [IDX_W-1:0] clr_addr_r;
  logic           out_valid_r;
  psbt_pkg::psbt_out_t out_r, res;

  // tag memory
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [EW-1:0]    ram_rdata;

  psbt_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (in_data.block_num[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // execute logic
  logic [7:0]  diff;
  logic        stale, rs, mark_new, wrap;
  logic [24:0] fill_sum;
  logic [23:0] fill_e;
  logic [15:0] count_e;
  logic        in_range;

  always_comb begin
    diff     = (item_r.sequence_number - cur_seq_r) & SEQ_MASK;
    stale    = seq_valid_r && (diff > SEQ_HALF);
    in_range = ({3'b0, layout_r} > item_r.block_num) &&
               ({1'b0, item_r.block_num} < BLOCK_LIMIT);
    rs       = 1'b0;
    mark_new = 1'b0;
    res      = '0;

    fill_nxt      = fill_r;
    count_nxt     = count_r;
    cur_seq_nxt   = cur_seq_r;
    seq_valid_nxt = seq_valid_r;
    expected_nxt  = expected_r;
    consumed_nxt  = consumed_r;

    case (item_r.command)
      psbt_pkg::CMD_CONSUMED: begin
        consumed_nxt = 1'b1;
        res.status   = psbt_pkg::ST_CONSUMED;
      end
      psbt_pkg::CMD_SEQUENCE: begin
        if (item_r.chroma_code != chroma_mode_r) begin
          res.status = psbt_pkg::ST_CHROMA;
        end else if (stale) begin
          res.status = psbt_pkg::ST_STALE;
        end else begin
          rs = !seq_valid_r || (diff != 8'd0);
          if (item_r.extended_code != psbt_pkg::START_OF_FRAME_CODE) begin
            res.status = psbt_pkg::ST_CODE;
          end else if ((({1'b0, item_r.width_minus_one} + 15'd1) != frame_width_r) ||
                       (({1'b0, item_r.height_minus_one} + 15'd1) != frame_height_r)) begin
            res.status = psbt_pkg::ST_DIMENSION;
          end else begin
            res.status = psbt_pkg::ST_SEQ_OK;
          end
        end
      end
      psbt_pkg::CMD_BLOCK: begin
        if (stale) begin
          res.status = psbt_pkg::ST_STALE;
        end else begin
          rs = !seq_valid_r || (diff != 8'd0);
          if (!in_range) begin
            res.status = psbt_pkg::ST_INDEX;
          end else if (!rs && (ram_rdata == epoch_r)) begin
            res.status = psbt_pkg::ST_DUPLICATE;
          end else begin
            mark_new = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (rs) begin
      fill_nxt      = '0;
      count_nxt     = '0;
      consumed_nxt  = 1'b0;
      expected_nxt  = {3'b0, layout_r};
      cur_seq_nxt   = item_r.sequence_number;
      seq_valid_nxt = 1'b1;
    end
    fill_e  = fill_nxt;
    count_e = count_nxt;
    fill_sum = {1'b0, fill_e} + {9'b0, item_r.word_count};

    if (res.status == psbt_pkg::ST_SEQ_OK && item_r.command == psbt_pkg::CMD_SEQUENCE) begin
      expected_nxt = item_r.block_total;
    end

    if (mark_new) begin
      if (count_e != COUNT_MAX) begin
        count_nxt = count_e + 16'd1;
      end
      res.block_offset = fill_e;
      if (item_r.word_count < HDR_WORDS) begin
        res.status = psbt_pkg::ST_SHORT;
      end else begin
        res.status = psbt_pkg::ST_NEW_BLOCK;
        fill_nxt = fill_sum[24] ? FILL_MAX : fill_sum[23:0];
      end
    end

    wrap      = rs && (epoch_r == {EW{1'b1}});
    epoch_nxt = epoch_r;
    if (rs) begin
      epoch_nxt = wrap ? EW'(1) : epoch_r + EW'(1);
    end

    res.restarted     = rs;
    res.decoded_count = count_nxt;
    res.frame_ready   = !consumed_nxt && seq_valid_nxt &&
                        ((count_nxt >= expected_nxt) ||
                         (allow_partial_r && (count_nxt > (expected_nxt >> 1))));
  end

  // tag memory write: clear pass or marking a new block
  always_comb begin
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = (pend_set_r && (clr_addr_r == pend_addr_r)) ? epoch_r : '0;
    end else begin
      ram_we    = cmd.commit && mark_new;
      ram_waddr = item_r.block_num[IDX_W-1:0];
      ram_wdata = epoch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.commit && (item_r.command != psbt_pkg::CMD_UNUSED)) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      count_r     <= '0;
      cur_seq_r   <= '0;
      seq_valid_r <= 1'b0;
      expected_r  <= '0;
      consumed_r  <= 1'b0;
      epoch_r     <= EW'(1);
      pend_set_r  <= 1'b0;
      pend_addr_r <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr_r <= (clr_addr_r == LAST_ADDR) ? '0 : clr_addr_r + IDX_W'(1);
      end
      if (cmd.commit) begin
        fill_r      <= fill_nxt;
        count_r     <= count_nxt;
        cur_seq_r   <= cur_seq_nxt;
        seq_valid_r <= seq_valid_nxt;
        expected_r  <= expected_nxt;
        consumed_r  <= consumed_nxt;
        epoch_r     <= epoch_nxt;
        pend_set_r  <= mark_new;
        pend_addr_r <= item_r.block_num[IDX_W-1:0];
      end
      if (cmd.commit && (item_r.command != psbt_pkg::CMD_UNUSED)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign sts.clear_last = (clr_addr_r == LAST_ADDR);
  assign sts.wrap       = wrap;
  assign sts.out_block  = out_valid_r && out_stall;

endmodule

/* rtl/packet_sequence_block_tracker.sv */
// packet sequence block tracker: one header in, one transaction out (none for command 3)
// result register loads in the execute state after accept; no item is taken until the last
// one commits, due to the read-modify-write of the seen tag memory; a result held by out_stall
// holds the next item; reset is synchronous; then a clearing pass over all MAX_BLOCKS tag
// addresses runs before the first item is taken and after every 255th sequence restart
// depends on psbt_pkg, psbt_ctrl, psbt_dp and psbt_ram
module packet_sequence_block_tracker #(
  parameter int MAX_BLOCKS    = 4096,
  parameter int SEQUENCE_MASK = 255,
  parameter int HEADER_WORDS  = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  psbt_pkg::psbt_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output psbt_pkg::psbt_out_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [psbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psbt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  psbt_pkg::psbt_cmd_t cmd;
  psbt_pkg::psbt_sts_t sts;

  psbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psbt_dp #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .SEQUENCE_MASK (SEQUENCE_MASK),
    .HEADER_WORDS  (HEADER_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* tb/tb_packet_sequence_block_tracker.sv */
// self-checking testbench for packet_sequence_block_tracker: directed and random header traffic
// predicts every result with its own copy of the tracking state; needs psbt_pkg and the rtl
module tb_packet_sequence_block_tracker;

  localparam int MAX_BLOCKS    = 4096;
  localparam int IDX_W         = $clog2(MAX_BLOCKS);
  localparam int SEQ_MASK      = 255;
  localparam int HEADER_WORDS  = 2;
  localparam int FILL_MAX      = 24'hFFFFFF;
  localparam int COUNT_MAX     = 16'hFFFF;
  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int PRINT_LIMIT   = 60;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  psbt_pkg::psbt_in_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  psbt_pkg::psbt_out_t             out_data;
  logic                            cfg_wr_en = 1'b0;
  logic [psbt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [psbt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // register copies
  logic [14:0] cfg_width = 15'd1;
  logic [14:0] cfg_height = 15'd1;
  logic [1:0]  cfg_chroma = 2'd0;
  logic [12:0] cfg_layout = 13'd0;
  logic        cfg_partial = 1'b0;

  // tracking state copies
  bit [MAX_BLOCKS-1:0] blk_seen = '0;
  logic [23:0] blk_fill = '0;
  logic [15:0] blk_accepted = '0;
  logic [7:0]  cur_seq = '0;
  logic        seq_valid = 1'b0;
  logic [15:0] blk_expected = '0;
  logic        frm_consumed = 1'b0;

  psbt_pkg::psbt_out_t predicted_results[$];
  int  error_count = 0;
  int  results_checked = 0;
  int  headers_sent = 0;
  int  restart_count = 0;
  int  hold_request = 0;
  bit  idle_on = 1'b1;

  packet_sequence_block_tracker #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .SEQUENCE_MASK(SEQ_MASK),
    .HEADER_WORDS(HEADER_WORDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic bit follow_sequence(input logic [7:0] seq, output bit restarted);
    logic [7:0] diff;
    diff = (seq - cur_seq) & SEQ_MASK[7:0];
    restarted = 1'b0;
    if (seq_valid && diff > SEQ_MASK / 2) return 1'b1;
    if (!seq_valid || diff != 0) begin
      blk_seen = '0;
      blk_fill = '0;
      blk_accepted = '0;
      frm_consumed = 1'b0;
      blk_expected = {3'b000, cfg_layout};
      cur_seq = seq;
      seq_valid = 1'b1;
      restarted = 1'b1;
      restart_count++;
    end
    return 1'b0;
  endfunction

  function automatic psbt_pkg::psbt_out_t track_header(input psbt_pkg::psbt_in_t h);
    psbt_pkg::psbt_out_t r;
    bit rs;
    int sum;
    r = '0;
    rs = 1'b0;
    if (h.command == psbt_pkg::CMD_CONSUMED) begin
      frm_consumed = 1'b1;
      r.status = psbt_pkg::ST_CONSUMED;
    end else if (h.command == psbt_pkg::CMD_SEQUENCE) begin
      if (h.chroma_code != cfg_chroma) begin
        r.status = psbt_pkg::ST_CHROMA;
      end else if (follow_sequence(h.sequence_number, rs)) begin
        r.status = psbt_pkg::ST_STALE;
      end else if (h.extended_code != psbt_pkg::START_OF_FRAME_CODE) begin
        r.status = psbt_pkg::ST_CODE;
      end else if (int'(h.width_minus_one) + 1 != int'(cfg_width) ||
                   int'(h.height_minus_one) + 1 != int'(cfg_height)) begin
        r.status = psbt_pkg::ST_DIMENSION;
      end else begin
        blk_expected = h.block_total;
        r.status = psbt_pkg::ST_SEQ_OK;
      end
    end else begin
      if (follow_sequence(h.sequence_number, rs)) begin
        r.status = psbt_pkg::ST_STALE;
      end else if (int'(h.block_num) >= int'(cfg_layout) ||
                   int'(h.block_num) >= MAX_BLOCKS) begin
        r.status = psbt_pkg::ST_INDEX;
      end else if (blk_seen[h.block_num[IDX_W-1:0]]) begin
        r.status = psbt_pkg::ST_DUPLICATE;
      end else begin
        blk_seen[h.block_num[IDX_W-1:0]] = 1'b1;
        if (int'(blk_accepted) < COUNT_MAX) blk_accepted++;
        r.block_offset = blk_fill;
        if (int'(h.word_count) < HEADER_WORDS) begin
          r.status = psbt_pkg::ST_SHORT;
        end else begin
          sum = int'(blk_fill) + int'(h.word_count);
          blk_fill = (sum > FILL_MAX) ? FILL_MAX[23:0] : sum[23:0];
          r.status = psbt_pkg::ST_NEW_BLOCK;
        end
      end
    end
    r.restarted = rs;
    r.decoded_count = blk_accepted;
    if (frm_consumed || !seq_valid) r.frame_ready = 1'b0;
    else if (blk_accepted < blk_expected &&
             (!cfg_partial || blk_accepted <= blk_expected / 2)) r.frame_ready = 1'b0;
    else r.frame_ready = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    psbt_pkg::psbt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (predicted_results.size() == 0) begin
        report_mismatch("transaction with nothing pending, status",
                        32'(out_data.status), 32'd0);
      end else begin
        want = predicted_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.block_offset !== want.block_offset)
          report_mismatch("block_offset", 32'(out_data.block_offset),
                          32'(want.block_offset));
        if (out_data.restarted !== want.restarted)
          report_mismatch("restarted", 32'(out_data.restarted), 32'(want.restarted));
        if (out_data.decoded_count !== want.decoded_count)
          report_mismatch("decoded_count", 32'(out_data.decoded_count),
                          32'(want.decoded_count));
        if (out_data.frame_ready !== want.frame_ready)
          report_mismatch("frame_ready", 32'(out_data.frame_ready), 32'(want.frame_ready));
      end
    end
  end

  // result side: random stall before each transaction while idle_on is set, or one long hold on request
  initial begin : result_receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_packet_sequence_block_tracker: done, errors");
    $finish;
  end

  task automatic send_header(input psbt_pkg::psbt_in_t h);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= h;
    do @(posedge clk); while (in_stall);
    headers_sent++;
    if (h.command != psbt_pkg::CMD_UNUSED)
      predicted_results = {predicted_results, track_header(h)};
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [psbt_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[psbt_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      psbt_pkg::CFG_FRAME_WIDTH:   cfg_width = value[14:0];
      psbt_pkg::CFG_FRAME_HEIGHT:  cfg_height = value[14:0];
      psbt_pkg::CFG_CHROMA_MODE:   cfg_chroma = value[1:0];
      psbt_pkg::CFG_LAYOUT_BLOCKS: cfg_layout = value[12:0];
      psbt_pkg::CFG_ALLOW_PARTIAL: cfg_partial = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int w, input int h, input int chroma, input int layout,
                              input int partial);
    wait_for_results();
    write_register(psbt_pkg::CFG_FRAME_WIDTH, w);
    write_register(psbt_pkg::CFG_FRAME_HEIGHT, h);
    write_register(psbt_pkg::CFG_CHROMA_MODE, chroma);
    write_register(psbt_pkg::CFG_LAYOUT_BLOCKS, layout);
    write_register(psbt_pkg::CFG_ALLOW_PARTIAL, partial);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic psbt_pkg::psbt_in_t random_hdr();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(psbt_pkg::psbt_in_t)-1:0];
  endfunction

  function automatic psbt_pkg::psbt_in_t block_hdr(input logic [7:0] seq,
                                                   input logic [15:0] idx,
                                                   input logic [15:0] words);
    psbt_pkg::psbt_in_t h;
    h = random_hdr();
    h.command = psbt_pkg::CMD_BLOCK;
    h.sequence_number = seq;
    h.block_num = idx;
    h.word_count = words;
    return h;
  endfunction

  // sequence header that matches the current chroma and picture size
  function automatic psbt_pkg::psbt_in_t seq_hdr(input logic [7:0] seq,
                                                 input logic [3:0] code,
                                                 input logic [15:0] total);
    psbt_pkg::psbt_in_t h;
    h = random_hdr();
    h.command = psbt_pkg::CMD_SEQUENCE;
    h.sequence_number = seq;
    h.chroma_code = cfg_chroma;
    h.extended_code = code;
    h.width_minus_one = 14'(cfg_width - 15'd1);
    h.height_minus_one = 14'(cfg_height - 15'd1);
    h.block_total = total;
    return h;
  endfunction

  function automatic psbt_pkg::psbt_in_t event_hdr(input logic [1:0] cmd);
    psbt_pkg::psbt_in_t h;
    h = random_hdr();
    h.command = cmd;
    return h;
  endfunction

  function automatic logic [15:0] pick_index();
    int lay;
    int span;
    lay = cfg_layout;
    span = (lay > 32) ? 32 : lay;
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(lay);
      2, 3: return (lay == 0) ? 16'd0 : 16'($urandom_range(0, lay - 1));
      default: return (span == 0) ? 16'd0 : 16'($urandom_range(0, span - 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_words();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 1));
      1: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(2, 300));
    endcase
  endfunction

  task automatic test_directed_headers();
    psbt_pkg::psbt_in_t h;
    apply_config(320, 240, 1, 16, 0);
    send_header(block_hdr(8'd5, 16'd0, 16'd10));
    send_header(block_hdr(8'd5, 16'd0, 16'd10));
    h = seq_hdr(8'd5, psbt_pkg::START_OF_FRAME_CODE, 16'd4);
    h.chroma_code = ~cfg_chroma;
    send_header(h);
    send_header(seq_hdr(8'd5, psbt_pkg::START_OF_FRAME_CODE, 16'd4));
    send_header(seq_hdr(8'd5, 4'hF, 16'd4));
    h = seq_hdr(8'd5, psbt_pkg::START_OF_FRAME_CODE, 16'd4);
    h.width_minus_one = 14'd320;
    send_header(h);
    h = seq_hdr(8'd5, psbt_pkg::START_OF_FRAME_CODE, 16'd4);
    h.height_minus_one = 14'd0;
    send_header(h);
    send_header(seq_hdr(8'd5, psbt_pkg::START_OF_FRAME_CODE, 16'd4));
    send_header(block_hdr(8'd5, 16'd1, 16'hFFFF));
    send_header(block_hdr(8'd5, 16'd2, 16'd1));
    send_header(block_hdr(8'd5, 16'd3, 16'd0));
    send_header(block_hdr(8'd5, 16'd15, 16'd2));
    send_header(block_hdr(8'd5, 16'd16, 16'd8));
    send_header(block_hdr(8'd5, 16'hFFFF, 16'd8));
    send_header(block_hdr(8'd133, 16'd4, 16'd8));
    send_header(seq_hdr(8'd133, psbt_pkg::START_OF_FRAME_CODE, 16'd4));
    send_header(event_hdr(psbt_pkg::CMD_CONSUMED));
    send_header(event_hdr(psbt_pkg::CMD_UNUSED));
    send_header(block_hdr(8'd6, 16'd5, 16'd3));
    send_header(seq_hdr(8'd7, 4'd3, 16'd2));
    send_header(seq_hdr(8'd134, psbt_pkg::START_OF_FRAME_CODE, 16'd2));
    send_header(seq_hdr(8'd255, psbt_pkg::START_OF_FRAME_CODE, 16'd2));
    send_header(block_hdr(8'd0, 16'd20, 16'd3));
    send_header(block_hdr(8'd0, 16'd15, 16'd0));
    apply_config(16384, 16384, 3, 1, 1);
    send_header(seq_hdr(8'd1, psbt_pkg::START_OF_FRAME_CODE, 16'd0));
    send_header(block_hdr(8'd1, 16'd0, 16'd2));
    apply_config(1, 1, 0, 4096, 0);
    send_header(seq_hdr(8'd2, psbt_pkg::START_OF_FRAME_CODE, 16'hFFFF));
  endtask

  task automatic test_partial_frames();
    int i;
    apply_config(64, 48, 2, 8, 1);
    send_header(seq_hdr(8'd40, psbt_pkg::START_OF_FRAME_CODE, 16'd8));
    for (i = 0; i < 8; i++) begin
      send_header(block_hdr(8'd40, 16'(7 - i), 16'd5));
      if (i % 3 == 0) send_header(block_hdr(8'd40, 16'(7 - i), 16'd5));
    end
    // layout change takes effect on the block bound now and on the total at restart
    apply_config(64, 48, 2, 3, 1);
    send_header(block_hdr(8'd40, 16'd2, 16'd5));
    send_header(block_hdr(8'd40, 16'd5, 16'd5));
    send_header(block_hdr(8'd41, 16'd0, 16'd5));
    send_header(block_hdr(8'd41, 16'd1, 16'd5));
    apply_config(64, 48, 2, 3, 0);
    send_header(block_hdr(8'd41, 16'd2, 16'd5));
    send_header(event_hdr(psbt_pkg::CMD_CONSUMED));
    send_header(seq_hdr(8'd42, psbt_pkg::START_OF_FRAME_CODE, 16'd0));
  endtask

  task automatic test_fill_saturation();
    int i;
    apply_config(100, 100, 0, 4096, 0);
    send_header(seq_hdr(8'd90, psbt_pkg::START_OF_FRAME_CODE, 16'd262));
    for (i = 0; i < 260; i++) send_header(block_hdr(8'd90, 16'(i), 16'hFFFF));
    send_header(block_hdr(8'd90, 16'd4095, 16'd1));
    send_header(block_hdr(8'd90, 16'd4096, 16'd2));
  endtask

  task automatic test_long_stall();
    int i;
    apply_config(32, 32, 1, 16, 1);
    idle_on = 1'b0;
    hold_request = 300;
    send_header(seq_hdr(8'd10, psbt_pkg::START_OF_FRAME_CODE, 16'd12));
    for (i = 0; i < 40; i++) send_header(block_hdr(8'd10, pick_index(), pick_words()));
    wait_for_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int phase;
    int sent;
    int nblk;
    int r;
    logic [7:0] seq;
    psbt_pkg::psbt_in_t h;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_config(1, 1, 0, 0, 0);
        1: apply_config(16384, 16384, 3, 4096, 1);
        default: apply_config($urandom_range(1, 16384), $urandom_range(1, 16384),
                              $urandom_range(0, 3), $urandom_range(1, 64),
                              $urandom_range(0, 1));
      endcase
      sent = 0;
      seq = 8'($urandom);
      while (sent < 140) begin
        idle_on = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 9);
        if (r < 7) seq = seq + 8'd1;
        else if (r == 8) seq = seq + 8'($urandom_range(2, 127));
        else if (r == 9) seq = 8'($urandom);
        if ($urandom_range(0, 9) == 0) h = seq_hdr(seq, psbt_pkg::START_OF_FRAME_CODE,
                                                  16'($urandom_range(0, 65535)));
        else h = seq_hdr(seq, psbt_pkg::START_OF_FRAME_CODE,
                         16'($urandom_range(0, (cfg_layout > 24 ? 24 : cfg_layout) + 2)));
        case ($urandom_range(0, 19))
          0: h.chroma_code = 2'($urandom);
          1: h.extended_code = 4'($urandom);
          2: h.width_minus_one = 14'($urandom);
          3: h.height_minus_one = 14'($urandom);
          default: ;
        endcase
        send_header(h);
        sent++;
        nblk = $urandom_range(1, 24);
        repeat (nblk) begin
          r = $urandom_range(0, 19);
          if (r < 14) h = block_hdr(seq, pick_index(), pick_words());
          else if (r == 14) h = block_hdr(seq - 8'($urandom_range(1, 128)), pick_index(),
                                          pick_words());
          else if (r == 15) h = random_hdr();
          else if (r == 16) h = event_hdr(psbt_pkg::CMD_CONSUMED);
          else if (r == 17) begin
            seq = seq + 8'd1;
            h = block_hdr(seq, pick_index(), pick_words());
          end else if (r == 18) h = event_hdr(psbt_pkg::CMD_UNUSED);
          else h = block_hdr(seq, 16'($urandom), 16'($urandom));
          send_header(h);
          if (h.command != psbt_pkg::CMD_UNUSED) sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_headers();
    test_partial_frames();
    test_fill_saturation();
    test_long_stall();
    test_random_traffic();
    wait_for_results();
    $display("sent %0d headers, checked %0d results, saw %0d sequence restarts",
             headers_sent, results_checked, restart_count);
    $display("covered stale, duplicate, short, index, chroma, size, code and partial frames");
    if (error_count == 0) begin
      $display("tb_packet_sequence_block_tracker: done, clean");
    end else begin
      $display("tb_packet_sequence_block_tracker: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/psbt_pkg.sv
rtl/psbt_ram.sv
rtl/psbt_ctrl.sv
rtl/psbt_dp.sv
rtl/packet_sequence_block_tracker.sv
tb/tb_packet_sequence_block_tracker.sv
